// ===== design/array_list_insert_erase_unit_defines.svh =====
// assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef ARRAY_LIST_INSERT_ERASE_UNIT_DEFINES_SVH
`define ARRAY_LIST_INSERT_ERASE_UNIT_DEFINES_SVH

`define ALIE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ALIE_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== design/alie_pkg.sv =====
package alie_pkg;

	localparam int VAL_W = 32;
	localparam int CMD_W = 3;
	localparam int ST_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_INSERT     = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_POP_FRONT  = 3'd4,
		CMD_ERASE      = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// shift request broadcast to every cell
	typedef struct packed {
		logic open;
		logic close;
	} cell_ctl_t;

endpackage

// ===== design/array_list_insert_erase_unit.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells, one value per
// cell. Every item is one command (push back or front, insert before a 0-based index, pop
// back or front, erase a 1-based position) and gives exactly one result item with a status
// and the element count after the command. All cells shift toward or away from their
// neighbor in the same cycle, so a command's time does not depend on its position; a new item
// is accepted every cycle unless the output register holds a result not yet accepted; a new
// item is also taken while that result is being accepted downstream. Reset empties the list.
`include "array_list_insert_erase_unit_defines.svh"

module array_list_insert_erase_unit #(
	parameter int CAPACITY = 16,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int IW = ((alie_pkg::CMD_W + alie_pkg::VAL_W + CW + 7) / 8) * 8,
	localparam int OW = ((alie_pkg::ST_W + CW + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [IW-1:0] s_tdata,  // command, value, position
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [OW-1:0] m_tdata   // status, count
);
	import alie_pkg::*;

	localparam int VAL_LO = CMD_W;
	localparam int POS_LO = CMD_W + VAL_W;

	logic                    accept;
	cmd_t                    cmd;
	logic signed [VAL_W-1:0] value;
	logic [CW-1:0]           pos;
	status_t                 status;
	cell_ctl_t               ctl;
	logic [CW-1:0]           idx;
	logic [CW-1:0]           cnt_next;
	logic [CW-1:0]           count_q;
	status_t                 status_q;
	logic                    m_tvalid_q;
	logic signed [VAL_W-1:0] entry [CAPACITY];

	assign cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
	assign value = s_tdata[POS_LO-1:VAL_LO];
	assign pos   = s_tdata[POS_LO+CW-1:POS_LO];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	alie_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.go       (accept),
		.cmd      (cmd),
		.pos      (pos),
		.cnt      (count_q),
		.status   (status),
		.ctl      (ctl),
		.idx      (idx),
		.cnt_next (cnt_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_w;
		logic signed [VAL_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry[i+1];
		end

		alie_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.idx    (idx),
			.cnt    (count_q),
			.value  (value),
			.left   (left_w),
			.right  (right_w),
			.entry  (entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			status_q   <= ST_DONE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= cnt_next;
				status_q   <= status;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OW'({count_q, status_q});

	`ALIE_ASSERT(a_count_bound, (count_q <= CW'(CAPACITY)), "count above capacity")
	`ALIE_ASSERT_NEXT(a_full_holds, accept && status == ST_FULL, count_q == $past(count_q),
		"count moved on a full list")
	`ALIE_ASSERT_NEXT(a_push_grows,
		accept && status == ST_DONE && (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT),
		count_q == $past(count_q) + CW'(1), "push did not grow the list")
	`ALIE_ASSERT(a_out_count, (m_tvalid |-> m_tdata[ST_W+CW-1:ST_W] == count_q),
		"shown count differs from stored count")

endmodule

// ===== design/alie_cell.sv =====
module alie_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  alie_pkg::cell_ctl_t               ctl,
	input  logic [CW-1:0]                     idx,
	input  logic [CW-1:0]                     cnt,
	input  logic signed [alie_pkg::VAL_W-1:0] value,
	input  logic signed [alie_pkg::VAL_W-1:0] left,
	input  logic signed [alie_pkg::VAL_W-1:0] right,
	output logic signed [alie_pkg::VAL_W-1:0] entry
);
	import alie_pkg::*;

	localparam logic [CW:0] POS    = (CW+1)'(INDEX);
	localparam logic [CW:0] POS_P1 = (CW+1)'(INDEX + 1);

	logic signed [VAL_W-1:0] entry_q;
	logic signed [VAL_W-1:0] entry_d;
	logic [CW:0]             idx_w;
	logic [CW:0]             cnt_w;

	assign idx_w = {1'b0, idx};
	assign cnt_w = {1'b0, cnt};

	always_comb begin
		entry_d = entry_q;
		if (ctl.open) begin
			if (POS == idx_w) begin
				entry_d = value;
			end else if (POS > idx_w && POS <= cnt_w) begin
				entry_d = left;
			end
		end else if (ctl.close) begin
			if (POS_P1 == cnt_w) begin
				entry_d = '0;
			end else if (POS >= idx_w && POS_P1 < cnt_w) begin
				entry_d = right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

// ===== design/alie_ctrl.sv =====
module alie_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic                 go,
	input  alie_pkg::cmd_t       cmd,
	input  logic [CW-1:0]        pos,
	input  logic [CW-1:0]        cnt,
	output alie_pkg::status_t    status,
	output alie_pkg::cell_ctl_t  ctl,
	output logic [CW-1:0]        idx,
	output logic [CW-1:0]        cnt_next
);
	import alie_pkg::*;

	localparam logic [CW-1:0] CAP = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE = CW'(1);

	logic full;
	logic empty;
	logic open_op;
	logic close_op;

	assign full  = (cnt == CAP);
	assign empty = (cnt == '0);

	always_comb begin
		status   = ST_DONE;
		open_op  = 1'b0;
		close_op = 1'b0;
		idx      = '0;
		unique case (cmd)
			CMD_PUSH_BACK: begin
				idx = cnt;
				if (full) status = ST_FULL;
				else open_op = 1'b1;
			end
			CMD_PUSH_FRONT: begin
				if (full) status = ST_FULL;
				else open_op = 1'b1;
			end
			CMD_INSERT: begin
				idx = pos;
				if (full) status = ST_FULL;
				else if (pos >= cnt) status = ST_RANGE;
				else open_op = 1'b1;
			end
			CMD_POP_BACK: begin
				idx = cnt - ONE;
				if (empty) status = ST_EMPTY;
				else close_op = 1'b1;
			end
			CMD_POP_FRONT: begin
				if (empty) status = ST_EMPTY;
				else close_op = 1'b1;
			end
			CMD_ERASE: begin
				idx = pos - ONE;
				if (empty) status = ST_EMPTY;
				else if (pos == '0 || pos > cnt) status = ST_RANGE;
				else close_op = 1'b1;
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign ctl.open  = go & open_op;
	assign ctl.close = go & close_op;

	always_comb begin
		cnt_next = cnt;
		if (open_op) cnt_next = cnt + ONE;
		else if (close_op) cnt_next = cnt - ONE;
	end

endmodule
